// ===== hw/rtl/rfdm_pkg.sv =====
// Package for the radial falloff disc mask: widths, register indexes and the
// request, response and front-end payload types.
// Depends on nothing; every other file of the block uses it.
package rfdm_pkg;

   localparam int MAX_DIAMETER = 64;
   localparam int CHANNELS     = 4;
   localparam int NUM_OUT_CH   = 4;

   localparam int DIAM_W   = 7;
   localparam int COORD_W  = 6;
   localparam int VALUE_W  = 16;
   localparam int OFS_W    = 9;
   localparam int SQ_W     = 14;
   localparam int SUM_W    = 15;
   localparam int S_W      = 13;
   localparam int DD_W     = 13;
   localparam int D2_W     = 15;
   localparam int CSQ_W    = 32;
   localparam int T_W      = 45;
   localparam int P_W      = 30;
   localparam int Q_W      = 15;
   localparam int INC_W    = 46;

   localparam int SEARCH_STEPS = 15;
   localparam int LANE_LATENCY = SEARCH_STEPS + 3;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_DIAMETER = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLOUR0  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLOUR1  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLOUR2  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLOUR3  = 3'd4;

   localparam logic [DIAM_W-1:0] DIAMETER_RESET = 7'd16;

   typedef struct packed {
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
   } req_type;

   typedef struct packed {
      logic               inside_res;
      logic [VALUE_W-1:0] value_ch0;
      logic [VALUE_W-1:0] value_ch1;
      logic [VALUE_W-1:0] value_ch2;
      logic [VALUE_W-1:0] value_ch3;
   } rsp_type;

   typedef struct packed {
      logic            valid;
      logic            in_disc;
      logic [S_W-1:0]  s;
      logic [D2_W-1:0] d2;
   } front_type;

endpackage

// ===== hw/rtl/radial_falloff_disc_mask.sv =====
// Top level of the radial falloff disc mask: register file, shared front end,
// one lane per colour channel and the merging stage.
// Depends on rfdm_pkg, rfdm_front, rfdm_lane and rfdm_merge.
//
// The block takes one pixel request in every clock cycle and never raises
// busy. Each request gives exactly one response, strobed by rsp_valid for a
// single cycle; responses come out in request order and must be captured
// when strobed, as there is no back-pressure. A request passes through a
// three-stage front end, then the channel lanes (two multiplier stages
// followed by a fifteen-stage bit-by-bit search for the scale term and a
// lane result register) and one output register. Registers are to be
// written only while no request is in flight.
module radial_falloff_disc_mask (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  rfdm_pkg::req_type                req_data,
   input  logic                             csr_we,
   input  logic [rfdm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rfdm_pkg::CSR_DATA_W-1:0]  csr_data,
   output logic                             rsp_valid,
   output rfdm_pkg::rsp_type                rsp_data
);

   logic [rfdm_pkg::DIAM_W-1:0]                            diameter_ff;
   logic [rfdm_pkg::NUM_OUT_CH-1:0][rfdm_pkg::VALUE_W-1:0] colour_ff;
   logic [rfdm_pkg::NUM_OUT_CH-1:0][rfdm_pkg::VALUE_W-1:0] lane_value;
   logic                                                   accept;
   rfdm_pkg::front_type                                    front;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         diameter_ff <= rfdm_pkg::DIAMETER_RESET;
         colour_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            rfdm_pkg::CSR_DIAMETER: begin
               diameter_ff <= csr_data[rfdm_pkg::DIAM_W-1:0];
            end
            rfdm_pkg::CSR_COLOUR0: begin
               colour_ff[0] <= csr_data;
            end
            rfdm_pkg::CSR_COLOUR1: begin
               colour_ff[1] <= csr_data;
            end
            rfdm_pkg::CSR_COLOUR2: begin
               colour_ff[2] <= csr_data;
            end
            rfdm_pkg::CSR_COLOUR3: begin
               colour_ff[3] <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   rfdm_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req      (req_data),
      .diameter (diameter_ff),
      .front    (front)
   );

   for (genvar k = 0; k < rfdm_pkg::NUM_OUT_CH; k++) begin : g_lane
      if (k < rfdm_pkg::CHANNELS) begin : g_on
         rfdm_lane u_lane (
            .clock  (clock),
            .colour (colour_ff[k]),
            .s      (front.s),
            .d2     (front.d2),
            .value  (lane_value[k])
         );
      end else begin : g_off
         assign lane_value[k] = '0;
      end
   end

   rfdm_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .front      (front),
      .lane_value (lane_value),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

endmodule

// ===== hw/rtl/rfdm_front.sv =====
// Shared front end: offsets from the centre, squared radius, inside test and
// the squared doubled diameter handed to every channel lane.
// Depends on rfdm_pkg.
module rfdm_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  rfdm_pkg::req_type           req,
   input  logic [rfdm_pkg::DIAM_W-1:0] diameter,
   output rfdm_pkg::front_type         front
);

   logic                               v1_ff, v2_ff, v3_ff;
   logic [rfdm_pkg::DIAM_W-1:0]        d_in, d_ff;
   logic signed [rfdm_pkg::OFS_W-1:0]  a_in, a_ff, b_in, b_ff;
   logic signed [2*rfdm_pkg::OFS_W-1:0] asq_full, bsq_full;
   logic [2*rfdm_pkg::DIAM_W-1:0]      dd_full;
   logic [rfdm_pkg::SQ_W-1:0]          asq_ff, bsq_ff;
   logic [rfdm_pkg::DD_W-1:0]          dd_ff;
   logic [rfdm_pkg::SUM_W-1:0]         sum;
   logic                               inside_in, inside_ff;
   logic [rfdm_pkg::S_W-1:0]           s_in, s_ff;
   logic [rfdm_pkg::D2_W-1:0]          d2_ff;

   always_comb begin
      if (diameter > rfdm_pkg::DIAM_W'(rfdm_pkg::MAX_DIAMETER)) begin
         d_in = rfdm_pkg::DIAM_W'(rfdm_pkg::MAX_DIAMETER);
      end else begin
         d_in = diameter;
      end
      a_in = $signed({2'b00, req.row, 1'b0}) - $signed({2'b00, d_in}) + 9'sd1;
      b_in = $signed({2'b00, req.col, 1'b0}) - $signed({2'b00, d_in}) + 9'sd1;
   end

   assign asq_full = a_ff * a_ff;
   assign bsq_full = b_ff * b_ff;
   assign dd_full  = d_ff * d_ff;

   always_comb begin
      sum       = {1'b0, asq_ff} + {1'b0, bsq_ff};
      inside_in = (dd_ff != '0) && (sum <= {2'b00, dd_ff});
      s_in      = inside_in ? sum[rfdm_pkg::S_W-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      d_ff      <= d_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      asq_ff    <= asq_full[rfdm_pkg::SQ_W-1:0];
      bsq_ff    <= bsq_full[rfdm_pkg::SQ_W-1:0];
      dd_ff     <= dd_full[rfdm_pkg::DD_W-1:0];
      inside_ff <= inside_in;
      s_ff      <= s_in;
      d2_ff     <= {dd_ff, 2'b00};
   end

   assign front.valid   = v3_ff;
   assign front.in_disc = inside_ff;
   assign front.s       = s_ff;
   assign front.d2      = d2_ff;

endmodule

// ===== hw/rtl/rfdm_lane.sv =====
// One channel lane: forms t = c*c*s and searches, one quotient bit per stage,
// for the smallest q with d2*q*q >= t; the result is the colour minus q,
// floored at zero. Depends on rfdm_pkg.
module rfdm_lane (
   input  logic                         clock,
   input  logic [rfdm_pkg::VALUE_W-1:0] colour,
   input  logic [rfdm_pkg::S_W-1:0]     s,
   input  logic [rfdm_pkg::D2_W-1:0]    d2,
   output logic [rfdm_pkg::VALUE_W-1:0] value
);

   localparam int STEPS = rfdm_pkg::SEARCH_STEPS;

   logic [rfdm_pkg::CSQ_W-1:0]   csq_ff;
   logic [rfdm_pkg::S_W-1:0]     s_ff;
   logic [rfdm_pkg::D2_W-1:0]    d2_l1_ff;
   logic [rfdm_pkg::VALUE_W-1:0] c_l1_ff;
   logic [rfdm_pkg::T_W-1:0]     t_in;

   logic [rfdm_pkg::T_W-1:0]     rem_ff [0:STEPS];
   logic [rfdm_pkg::P_W-1:0]     p_ff   [0:STEPS];
   logic [rfdm_pkg::Q_W-1:0]     q_ff   [0:STEPS];
   logic [rfdm_pkg::D2_W-1:0]    d2_ff  [0:STEPS];
   logic [rfdm_pkg::VALUE_W-1:0] c_ff   [0:STEPS];

   logic [rfdm_pkg::INC_W-1:0]   incr   [0:STEPS-1];
   logic [STEPS-1:0]             take;

   logic [rfdm_pkg::VALUE_W-1:0] q_total;
   logic [rfdm_pkg::VALUE_W-1:0] value_in, value_ff;

   assign t_in = csq_ff * s_ff;

   // Each stage tries to set one bit of q, keeping rem = t - d2*q*q and p = d2*q.
   always_comb begin
      for (int i = 0; i < STEPS; i++) begin
         incr[i] = (rfdm_pkg::INC_W'(p_ff[i]) << (STEPS - i))
                 + (rfdm_pkg::INC_W'(d2_ff[i]) << (2 * (STEPS - 1 - i)));
         take[i] = {1'b0, rem_ff[i]} > incr[i];
      end
   end

   always_ff @(posedge clock) begin
      csq_ff    <= colour * colour;
      s_ff      <= s;
      d2_l1_ff  <= d2;
      c_l1_ff   <= colour;
      rem_ff[0] <= t_in;
      p_ff[0]   <= '0;
      q_ff[0]   <= '0;
      d2_ff[0]  <= d2_l1_ff;
      c_ff[0]   <= c_l1_ff;
      for (int i = 0; i < STEPS; i++) begin
         if (take[i]) begin
            rem_ff[i+1] <= rem_ff[i] - incr[i][rfdm_pkg::T_W-1:0];
            p_ff[i+1]   <= p_ff[i] + (rfdm_pkg::P_W'(d2_ff[i]) << (STEPS - 1 - i));
            q_ff[i+1]   <= q_ff[i] | (rfdm_pkg::Q_W'(1) << (STEPS - 1 - i));
         end else begin
            rem_ff[i+1] <= rem_ff[i];
            p_ff[i+1]   <= p_ff[i];
            q_ff[i+1]   <= q_ff[i];
         end
         d2_ff[i+1] <= d2_ff[i];
         c_ff[i+1]  <= c_ff[i];
      end
   end

   always_comb begin
      if (rem_ff[STEPS] != '0) begin
         q_total = {1'b0, q_ff[STEPS]} + 16'd1;
      end else begin
         q_total = '0;
      end
      if (q_total > c_ff[STEPS]) begin
         value_in = '0;
      end else begin
         value_in = c_ff[STEPS] - q_total;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

// ===== hw/rtl/rfdm_merge.sv =====
// Merging stage: delays the valid and inside flags past the lanes and packs the
// lane results into the response register, zeroing pixels outside the disc.
// Depends on rfdm_pkg.
module rfdm_merge (
   input  logic                                             clock,
   input  logic                                             reset,
   input  rfdm_pkg::front_type                              front,
   input  logic [rfdm_pkg::NUM_OUT_CH-1:0][rfdm_pkg::VALUE_W-1:0] lane_value,
   output logic                                             rsp_valid,
   output rfdm_pkg::rsp_type                                rsp_data
);

   localparam int DLY = rfdm_pkg::LANE_LATENCY;

   logic [DLY-1:0]                                         valid_dly_ff;
   logic [DLY-1:0]                                         inside_dly_ff;
   logic                                                   in_disc;
   logic [rfdm_pkg::NUM_OUT_CH-1:0][rfdm_pkg::VALUE_W-1:0] masked;
   logic                                                   rsp_valid_ff;
   rfdm_pkg::rsp_type                                      rsp_data_in, rsp_data_ff;

   assign in_disc = inside_dly_ff[DLY-1];

   always_comb begin
      for (int k = 0; k < rfdm_pkg::NUM_OUT_CH; k++) begin
         masked[k] = in_disc ? lane_value[k] : '0;
      end
      rsp_data_in.inside_res = in_disc;
      rsp_data_in.value_ch0  = masked[0];
      rsp_data_in.value_ch1  = masked[1];
      rsp_data_in.value_ch2  = masked[2];
      rsp_data_in.value_ch3  = masked[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_dly_ff  <= '0;
         inside_dly_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         valid_dly_ff  <= {valid_dly_ff[DLY-2:0], front.valid};
         inside_dly_ff <= {inside_dly_ff[DLY-2:0], front.in_disc};
         rsp_valid_ff  <= valid_dly_ff[DLY-1];
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== verif/radial_falloff_disc_mask_tb.sv =====
// Self-checking testbench for radial_falloff_disc_mask: directed and random pixel requests
// under several register settings, checked against a built-in disc and falloff predictor.
// Depends on rfdm_pkg and the radial_falloff_disc_mask RTL.
module radial_falloff_disc_mask_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RSP_LATENCY = 22;
   localparam int RANDOM_PHASES = 12;
   localparam int PIXELS_PER_PHASE = 150;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             start = 1'b0;
   logic                             busy;
   rfdm_pkg::req_type                req_data = '0;
   logic                             csr_we = 1'b0;
   logic [rfdm_pkg::CSR_INDEX_W-1:0] csr_index = rfdm_pkg::CSR_DIAMETER;
   logic [rfdm_pkg::CSR_DATA_W-1:0]  csr_data = '0;
   logic                             rsp_valid;
   rfdm_pkg::rsp_type                rsp_data;

   logic [rfdm_pkg::DIAM_W-1:0]  diam_cfg = rfdm_pkg::DIAMETER_RESET;
   logic [rfdm_pkg::VALUE_W-1:0] colour_cfg [rfdm_pkg::NUM_OUT_CH] = '{default: '0};

   rfdm_pkg::req_type pending_pixels [$];
   rfdm_pkg::rsp_type expected_pixels [$];
   logic    req_taken = 1'b0;
   int      gap_pct = 27;
   int      mismatches = 0;

   radial_falloff_disc_mask DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned r;
      longint unsigned cand;
      r = 0;
      for (int i = 24; i >= 0; i--) begin
         cand = r | (64'd1 << i);
         if (cand * cand <= v) r = cand;
      end
      return r;
   endfunction

   function automatic logic [rfdm_pkg::VALUE_W-1:0] falloff_value(
         logic [rfdm_pkg::VALUE_W-1:0] c, int unsigned s, int d);
      longint unsigned cc;
      longint unsigned t;
      longint unsigned r;
      longint unsigned m;
      longint unsigned q;
      cc = c;
      t = cc * cc * s;
      r = root_floor(t);
      if (r * r < t) r = r + 1;
      m = 2 * d;
      q = (r + m - 1) / m;
      return (q > cc) ? '0 : rfdm_pkg::VALUE_W'(cc - q);
   endfunction

   function automatic rfdm_pkg::rsp_type predict_pixel(rfdm_pkg::req_type px);
      int                           d_eff;
      int                           a;
      int                           b;
      int unsigned                  s;
      logic                         in_disc;
      logic [rfdm_pkg::VALUE_W-1:0] vals [rfdm_pkg::NUM_OUT_CH];
      rfdm_pkg::rsp_type            r;
      d_eff = (diam_cfg > rfdm_pkg::MAX_DIAMETER) ? rfdm_pkg::MAX_DIAMETER : int'(diam_cfg);
      a = 2 * int'(px.row) - (d_eff - 1);
      b = 2 * int'(px.col) - (d_eff - 1);
      s = a * a + b * b;
      in_disc = (d_eff != 0) && (s <= d_eff * d_eff);
      for (int k = 0; k < rfdm_pkg::NUM_OUT_CH; k++)
         vals[k] = (in_disc && k < rfdm_pkg::CHANNELS) ?
                   falloff_value(colour_cfg[k], s, d_eff) : '0;
      r.inside_res = in_disc;
      r.value_ch0 = vals[0];
      r.value_ch1 = vals[1];
      r.value_ch2 = vals[2];
      r.value_ch3 = vals[3];
      return r;
   endfunction

   function automatic void check_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, field, want, got);
      end
   endfunction

   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || req_taken) begin
         if (pending_pixels.size() != 0 && $urandom_range(99) >= gap_pct) begin
            req_data <= pending_pixels.pop_front();
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rfdm_pkg::rsp_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         if (rsp_valid) begin
            if (expected_pixels.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: response with no request outstanding", $realtime);
            end else begin
               want = expected_pixels.pop_front();
               check_field("inside_res", want.inside_res, rsp_data.inside_res);
               check_field("value_ch0", want.value_ch0, rsp_data.value_ch0);
               check_field("value_ch1", want.value_ch1, rsp_data.value_ch1);
               check_field("value_ch2", want.value_ch2, rsp_data.value_ch2);
               check_field("value_ch3", want.value_ch3, rsp_data.value_ch3);
            end
         end
         req_taken <= start && !busy;
         if (start && !busy) expected_pixels.push_back(predict_pixel(req_data));
      end
   end

   task automatic write_reg(logic [rfdm_pkg::CSR_INDEX_W-1:0] index,
                            logic [rfdm_pkg::CSR_DATA_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      case (index)
         rfdm_pkg::CSR_DIAMETER: diam_cfg = data[rfdm_pkg::DIAM_W-1:0];
         rfdm_pkg::CSR_COLOUR0:  colour_cfg[0] = data;
         rfdm_pkg::CSR_COLOUR1:  colour_cfg[1] = data;
         rfdm_pkg::CSR_COLOUR2:  colour_cfg[2] = data;
         rfdm_pkg::CSR_COLOUR3:  colour_cfg[3] = data;
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic set_config(logic [rfdm_pkg::DIAM_W-1:0] diam,
                             logic [rfdm_pkg::VALUE_W-1:0] c0,
                             logic [rfdm_pkg::VALUE_W-1:0] c1,
                             logic [rfdm_pkg::VALUE_W-1:0] c2,
                             logic [rfdm_pkg::VALUE_W-1:0] c3);
      logic [rfdm_pkg::CSR_INDEX_W-1:0] spare;
      spare = rfdm_pkg::CSR_INDEX_W'($urandom_range(7, 5));
      write_reg(rfdm_pkg::CSR_DIAMETER,
                {(rfdm_pkg::CSR_DATA_W - rfdm_pkg::DIAM_W)'($urandom), diam});
      write_reg(rfdm_pkg::CSR_COLOUR0, c0);
      write_reg(rfdm_pkg::CSR_COLOUR1, c1);
      write_reg(spare, rfdm_pkg::CSR_DATA_W'($urandom));
      write_reg(rfdm_pkg::CSR_COLOUR2, c2);
      write_reg(rfdm_pkg::CSR_COLOUR3, c3);
      csr_we <= 1'b0;
   endtask

   task automatic settle();
      while (pending_pixels.size() != 0 || start || expected_pixels.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic push_pixel(int r, int c);
      rfdm_pkg::req_type px;
      px.row = rfdm_pkg::COORD_W'(r);
      px.col = rfdm_pkg::COORD_W'(c);
      pending_pixels.push_back(px);
   endtask

   function automatic logic [rfdm_pkg::VALUE_W-1:0] pick_colour();
      case ($urandom_range(5))
         0: return '0;
         1: return '1;
         default: return rfdm_pkg::VALUE_W'($urandom);
      endcase
   endfunction

   initial begin
      int diam_list [RANDOM_PHASES];
      int d_eff;
      diam_list = '{64, 1, 2, 0, 127, 65, 5, 16, 33, 64, 40, -1};
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      gap_pct = 27;
      set_config(7'd64, 16'hFFFF, 16'h0000, 16'h8000, 16'h0001);
      push_pixel(0, 0);   push_pixel(0, 63);  push_pixel(63, 0);  push_pixel(63, 63);
      push_pixel(31, 31); push_pixel(32, 32); push_pixel(31, 32); push_pixel(0, 31);
      push_pixel(0, 32);  push_pixel(31, 0);  push_pixel(63, 32);
      settle();
      set_config(7'd16, pick_colour(), pick_colour(), pick_colour(), pick_colour());
      push_pixel(7, 7);   push_pixel(8, 8);   push_pixel(15, 15);
      push_pixel(16, 3);  push_pixel(3, 40);  push_pixel(63, 63);
      settle();
      set_config(7'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      push_pixel(0, 0);   push_pixel(5, 9);
      settle();
      set_config(7'd1, 16'hFFFF, 16'h1234, 16'h0001, 16'h0000);
      push_pixel(0, 0);   push_pixel(0, 1);
      settle();
      set_config(7'd100, 16'hFFFF, 16'hABCD, 16'h7FFF, 16'h0002);
      push_pixel(0, 0);   push_pixel(31, 32); push_pixel(63, 63);
      settle();

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         gap_pct = (ph < 4) ? 27 : (ph < 8) ? 81 : 0;
         set_config((diam_list[ph] < 0) ? rfdm_pkg::DIAM_W'($urandom_range(64, 1)) :
                                          rfdm_pkg::DIAM_W'(diam_list[ph]),
                    pick_colour(), pick_colour(), pick_colour(), pick_colour());
         d_eff = (diam_cfg > rfdm_pkg::MAX_DIAMETER) ? rfdm_pkg::MAX_DIAMETER :
                                                       int'(diam_cfg);
         for (int n = 0; n < PIXELS_PER_PHASE; n++) begin
            if (d_eff == 0 || $urandom_range(99) < 20)
               push_pixel($urandom_range(63), $urandom_range(63));
            else
               push_pixel($urandom_range(d_eff - 1), $urandom_range(d_eff - 1));
         end
         settle();
      end

      repeat (RSP_LATENCY + 8) @(negedge clock);
      mismatches += expected_pixels.size();
      if (mismatches == 0) begin
         $display("** radial_falloff_disc_mask: PASSED **");
      end else begin
         $display("** radial_falloff_disc_mask: FAILED **");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("** radial_falloff_disc_mask: FAILED **");
      $finish;
   end

endmodule
